// File: sv/fcwrb_pkg.sv
// Shared constants, types and width helpers for the four-channel window ring buffer.
`timescale 1ns / 1ps

package fcwrb_pkg;

   localparam int CHANNEL_DEPTH = 16;
   localparam int SAMPLE_WIDTH  = 32;

   localparam int NUM_CHANNELS = 4;
   localparam int CH_W         = $clog2(NUM_CHANNELS);
   localparam int PTR_W        = (CHANNEL_DEPTH > 1) ? $clog2(CHANNEL_DEPTH) : 1;

   localparam int WORD_W = 32;
   localparam int CODE_W = 4;
   localparam int AGE_W  = 4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CODE_W-1:0] CODE_FIRST = CODE_W'(3);
   localparam logic [CODE_W-1:0] CODE_LAST  = CODE_W'(6);

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [CH_W-1:0]         channel;
      logic [SAMPLE_WIDTH-1:0] sample;
   } cmd_type;

   // Zero-extend or truncate an incoming word to the stored sample width.
   function automatic logic [SAMPLE_WIDTH-1:0] fit_in(input logic [WORD_W-1:0] word);
      logic [SAMPLE_WIDTH-1:0] result;
      result = '0;
      for (int i = 0; i < SAMPLE_WIDTH; i++) begin
         if (i < WORD_W) begin
            result[i] = word[i];
         end
      end
      return result;
   endfunction

   // Low word of a stored sample, zero-filled if the sample is narrower.
   function automatic logic [WORD_W-1:0] fit_out(input logic [SAMPLE_WIDTH-1:0] sample);
      logic [WORD_W-1:0] result;
      result = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (i < SAMPLE_WIDTH) begin
            result[i] = sample[i];
         end
      end
      return result;
   endfunction

endpackage

// File: sv/four_channel_window_ring_buffer_unit.sv
// Top level of the four-channel window ring buffer: front end, command queue and back end.
//
//   channel   ports                                            handshake
//   request   req_operation, req_channel_code, req_sample_bits start high, busy low
//   result    rsp_window_sample, rsp_sample_channel,           rsp_strobe, one cycle,
//             rsp_sample_age, rsp_last_of_window               no back-pressure
//
// A push holds the back end while its command is taken; a readout takes the command,
// then makes one store read per cycle over every entry of every channel, with each result
// registered in the next cycle. The single store read port sets the readout rate.
// Requests queue in a two-entry command queue; busy rises only while it is full. Reset
// clears the pointers and per-entry fill bits, so the block takes items right after reset.
`timescale 1ns / 1ps

module four_channel_window_ring_buffer_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_operation,
   input  logic [fcwrb_pkg::CODE_W-1:0]       req_channel_code,
   input  logic [fcwrb_pkg::WORD_W-1:0]       req_sample_bits,
   output logic                               rsp_strobe,
   output logic [fcwrb_pkg::WORD_W-1:0]       rsp_window_sample,
   output logic [fcwrb_pkg::CH_W-1:0]         rsp_sample_channel,
   output logic [fcwrb_pkg::AGE_W-1:0]        rsp_sample_age,
   output logic                               rsp_last_of_window
);

   logic               q_valid;
   logic               q_pop;
   fcwrb_pkg::cmd_type q_cmd;

   fcwrb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_channel_code (req_channel_code),
      .req_sample_bits  (req_sample_bits),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop)
   );

   fcwrb_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_cmd              (q_cmd),
      .q_pop              (q_pop),
      .rsp_strobe         (rsp_strobe),
      .rsp_window_sample  (rsp_window_sample),
      .rsp_sample_channel (rsp_sample_channel),
      .rsp_sample_age     (rsp_sample_age),
      .rsp_last_of_window (rsp_last_of_window)
   );

endmodule

// File: sv/fcwrb_front.sv
// Front end: accepts items, drops pushes with unknown sensor codes, queues commands for the back end.
`timescale 1ns / 1ps

module fcwrb_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_operation,
   input  logic [fcwrb_pkg::CODE_W-1:0]       req_channel_code,
   input  logic [fcwrb_pkg::WORD_W-1:0]       req_sample_bits,
   output logic                               q_valid,
   output fcwrb_pkg::cmd_type                 q_cmd,
   input  logic                               q_pop
);

   fcwrb_pkg::cmd_type                q_mem_ff [fcwrb_pkg::QUEUE_DEPTH];
   logic [fcwrb_pkg::QPTR_W-1:0]      q_wr_ff, q_wr_in;
   logic [fcwrb_pkg::QPTR_W-1:0]      q_rd_ff, q_rd_in;
   logic [fcwrb_pkg::QCNT_W-1:0]      q_count_ff, q_count_in;

   logic                              accept;
   logic                              keep;
   logic                              q_push;
   fcwrb_pkg::cmd_type                new_cmd;
   logic [fcwrb_pkg::CH_W-1:0]        code_offset;

   localparam logic [fcwrb_pkg::QPTR_W-1:0] QPTR_LAST =
      fcwrb_pkg::QPTR_W'(fcwrb_pkg::QUEUE_DEPTH - 1);
   localparam logic [fcwrb_pkg::QCNT_W-1:0] QCNT_FULL =
      fcwrb_pkg::QCNT_W'(fcwrb_pkg::QUEUE_DEPTH);

   assign busy   = (q_count_ff == QCNT_FULL);
   assign accept = start && !busy;

   // Classify: readouts always go through, pushes only with a known sensor code.
   assign code_offset = fcwrb_pkg::CH_W'(req_channel_code - fcwrb_pkg::CODE_FIRST);

   always_comb begin
      new_cmd.op      = fcwrb_pkg::op_type'(req_operation);
      new_cmd.channel = code_offset;
      new_cmd.sample  = fcwrb_pkg::fit_in(req_sample_bits);
      keep = (new_cmd.op == fcwrb_pkg::OP_READ) ||
             ((req_channel_code >= fcwrb_pkg::CODE_FIRST) &&
              (req_channel_code <= fcwrb_pkg::CODE_LAST));
   end

   assign q_push = accept && keep;

   always_comb begin
      q_wr_in    = q_wr_ff;
      q_rd_in    = q_rd_ff;
      q_count_in = q_count_ff;
      if (q_push) begin
         q_wr_in = (q_wr_ff == QPTR_LAST) ? '0 : q_wr_ff + 1'b1;
      end
      if (q_pop) begin
         q_rd_in = (q_rd_ff == QPTR_LAST) ? '0 : q_rd_ff + 1'b1;
      end
      if (q_push && !q_pop) begin
         q_count_in = q_count_ff + 1'b1;
      end else if (!q_push && q_pop) begin
         q_count_in = q_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff    <= '0;
         q_rd_ff    <= '0;
         q_count_ff <= '0;
      end else begin
         q_wr_ff    <= q_wr_in;
         q_rd_ff    <= q_rd_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem_ff[q_wr_ff] <= new_cmd;
      end
   end

   assign q_valid = (q_count_ff != '0);
   assign q_cmd   = q_mem_ff[q_rd_ff];

`ifndef SYNTHESIS
   property count_bounded_p;
      @(posedge clock) disable iff (reset) q_count_ff <= QCNT_FULL;
   endproperty
   count_bounded_a: assert property (count_bounded_p)
      else $error("command queue count above depth");

   property pop_nonempty_p;
      @(posedge clock) disable iff (reset) q_pop |-> (q_count_ff != '0);
   endproperty
   pop_nonempty_a: assert property (pop_nonempty_p)
      else $error("command queue popped while empty");

   property pop_drains_p;
      @(posedge clock) disable iff (reset)
         (q_pop && !q_push) |=> (q_count_ff == $past(q_count_ff - fcwrb_pkg::QCNT_W'(1)));
   endproperty
   pop_drains_a: assert property (pop_drains_p)
      else $error("command queue count did not drop on pop");
`endif

endmodule

// File: sv/fcwrb_back.sv
// Back end: executes pushes into the sample store and sequences window readouts.
`timescale 1ns / 1ps

module fcwrb_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   input  fcwrb_pkg::cmd_type                 q_cmd,
   output logic                               q_pop,
   output logic                               rsp_strobe,
   output logic [fcwrb_pkg::WORD_W-1:0]       rsp_window_sample,
   output logic [fcwrb_pkg::CH_W-1:0]         rsp_sample_channel,
   output logic [fcwrb_pkg::AGE_W-1:0]        rsp_sample_age,
   output logic                               rsp_last_of_window
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } back_state_type;

   localparam int PW = fcwrb_pkg::PTR_W;
   localparam logic [PW-1:0] PTR_LAST   = PW'(fcwrb_pkg::CHANNEL_DEPTH - 1);
   localparam logic [PW:0]   DEPTH_WIDE = (PW + 1)'(fcwrb_pkg::CHANNEL_DEPTH);
   localparam logic [fcwrb_pkg::CH_W-1:0] CH_LAST = fcwrb_pkg::CH_W'(fcwrb_pkg::NUM_CHANNELS - 1);

   back_state_type state_ff, state_in;

   logic [fcwrb_pkg::NUM_CHANNELS-1:0][PW-1:0]                      ptr_ff, ptr_in;
   logic [fcwrb_pkg::NUM_CHANNELS-1:0][fcwrb_pkg::CHANNEL_DEPTH-1:0] fill_ff, fill_in;
   logic [fcwrb_pkg::SAMPLE_WIDTH-1:0] mem_ff [fcwrb_pkg::NUM_CHANNELS][fcwrb_pkg::CHANNEL_DEPTH];

   logic [fcwrb_pkg::CH_W-1:0] ch_ff, ch_in;
   logic [PW-1:0]              age_ff, age_in;

   logic [fcwrb_pkg::SAMPLE_WIDTH-1:0] rd_data_ff;
   logic                               rd_fill_ff;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   logic [fcwrb_pkg::CH_W-1:0]         rsp_ch_ff;
   logic [PW-1:0]                      rsp_age_ff;
   logic                               rsp_last_ff;

   logic          do_write;
   logic          reading;
   logic          issue_last;
   logic [PW:0]   slot_sum;
   logic [PW-1:0] slot;
   logic [PW-1:0] wr_slot;

   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign do_write = q_pop && (q_cmd.op == fcwrb_pkg::OP_PUSH);
   assign reading  = (state_ff == ST_READ);
   assign wr_slot  = ptr_ff[q_cmd.channel];

   assign issue_last = (age_ff == PTR_LAST) && (ch_ff == CH_LAST);

   // Slot of the current age: oldest pointer plus age, wrapped once.
   always_comb begin
      slot_sum = {1'b0, ptr_ff[ch_ff]} + {1'b0, age_ff};
      if (slot_sum >= DEPTH_WIDE) begin
         slot_sum = slot_sum - DEPTH_WIDE;
      end
      slot = slot_sum[PW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      age_in   = age_ff;
      ptr_in   = ptr_ff;
      fill_in  = fill_ff;
      case (state_ff)
         ST_IDLE: begin
            if (do_write) begin
               fill_in[q_cmd.channel][wr_slot] = 1'b1;
               ptr_in[q_cmd.channel] = (wr_slot == PTR_LAST) ? '0 : wr_slot + 1'b1;
            end else if (q_pop) begin
               state_in = ST_READ;
               ch_in    = '0;
               age_in   = '0;
            end
         end
         ST_READ: begin
            // Advance channel first, then age; leave after the newest entry of channel 3.
            if (ch_ff == CH_LAST) begin
               ch_in  = '0;
               age_in = (age_ff == PTR_LAST) ? '0 : age_ff + 1'b1;
            end else begin
               ch_in = ch_ff + 1'b1;
            end
            if (issue_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe_in = reading;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ch_ff         <= '0;
         age_ff        <= '0;
         ptr_ff        <= '0;
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ch_ff         <= ch_in;
         age_ff        <= age_in;
         ptr_ff        <= ptr_in;
         fill_ff       <= fill_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ff[q_cmd.channel][wr_slot] <= q_cmd.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reading) begin
         rd_data_ff  <= mem_ff[ch_ff][slot];
         rd_fill_ff  <= fill_ff[ch_ff][slot];
         rsp_ch_ff   <= ch_ff;
         rsp_age_ff  <= age_ff;
         rsp_last_ff <= issue_last;
      end
   end

   // Entries never pushed read as the zero fill value.
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_window_sample  = rd_fill_ff ? fcwrb_pkg::fit_out(rd_data_ff) : '0;
   assign rsp_sample_channel = rsp_ch_ff;
   assign rsp_sample_age     = fcwrb_pkg::AGE_W'(rsp_age_ff);
   assign rsp_last_of_window = rsp_last_ff;

`ifndef SYNTHESIS
   property strobe_from_read_p;
      @(posedge clock) disable iff (reset) rsp_strobe_ff |-> $past(state_ff == ST_READ);
   endproperty
   strobe_from_read_a: assert property (strobe_from_read_p)
      else $error("result strobe without a readout cycle");

   property last_ends_read_p;
      @(posedge clock) disable iff (reset)
         (reading && issue_last) |=> (state_ff == ST_IDLE && rsp_strobe_ff && rsp_last_ff);
   endproperty
   last_ends_read_a: assert property (last_ends_read_p)
      else $error("readout did not close with a flagged last item");

   property read_holds_state_p;
      @(posedge clock) disable iff (reset)
         reading |=> ($stable(ptr_ff) && $stable(fill_ff));
   endproperty
   read_holds_state_a: assert property (read_holds_state_p)
      else $error("window state changed during readout");
`endif

endmodule

// File: tb/sv/window_checker.sv
// Checker for the four-channel window ring buffer: tracks the windows and compares readouts.
`timescale 1ns / 1ps

module window_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic                              req_operation,
   input  logic [fcwrb_pkg::CODE_W-1:0]      req_channel_code,
   input  logic [fcwrb_pkg::WORD_W-1:0]      req_sample_bits,
   input  logic                              rsp_strobe,
   input  logic [fcwrb_pkg::WORD_W-1:0]      rsp_window_sample,
   input  logic [fcwrb_pkg::CH_W-1:0]        rsp_sample_channel,
   input  logic [fcwrb_pkg::AGE_W-1:0]       rsp_sample_age,
   input  logic                              rsp_last_of_window,
   output int                                error_count,
   output int                                pending_results
);

   typedef struct packed {
      logic [fcwrb_pkg::WORD_W-1:0] sample;
      logic [fcwrb_pkg::CH_W-1:0]   channel;
      logic [fcwrb_pkg::AGE_W-1:0]  age;
      logic                         last;
   } window_entry_type;

   logic [fcwrb_pkg::SAMPLE_WIDTH-1:0] channel_window [fcwrb_pkg::NUM_CHANNELS]
                                                      [fcwrb_pkg::CHANNEL_DEPTH];
   int               oldest_slot [fcwrb_pkg::NUM_CHANNELS];
   window_entry_type expected_window [$];

   task automatic clear_windows();
      for (int ch = 0; ch < fcwrb_pkg::NUM_CHANNELS; ch++) begin
         oldest_slot[ch] = 0;
         for (int i = 0; i < fcwrb_pkg::CHANNEL_DEPTH; i++) begin
            channel_window[ch][i] = '0;
         end
      end
      expected_window.delete();
   endtask

   // Overwrite the oldest entry of the selected channel; drop unknown sensor codes.
   task automatic store_sample(input logic [fcwrb_pkg::CODE_W-1:0] code,
                               input logic [fcwrb_pkg::WORD_W-1:0] word);
      int ch;
      if (code >= fcwrb_pkg::CODE_FIRST && code <= fcwrb_pkg::CODE_LAST) begin
         ch = int'(code - fcwrb_pkg::CODE_FIRST);
         channel_window[ch][oldest_slot[ch]] = fcwrb_pkg::SAMPLE_WIDTH'(word);
         oldest_slot[ch] = (oldest_slot[ch] + 1) % fcwrb_pkg::CHANNEL_DEPTH;
      end
   endtask

   // Snapshot every window, oldest age first, channels interleaved.
   task automatic predict_readout();
      window_entry_type entry;
      int               slot;
      for (int age = 0; age < fcwrb_pkg::CHANNEL_DEPTH; age++) begin
         for (int ch = 0; ch < fcwrb_pkg::NUM_CHANNELS; ch++) begin
            slot          = (oldest_slot[ch] + age) % fcwrb_pkg::CHANNEL_DEPTH;
            entry.sample  = fcwrb_pkg::WORD_W'(channel_window[ch][slot]);
            entry.channel = fcwrb_pkg::CH_W'(ch);
            entry.age     = fcwrb_pkg::AGE_W'(age);
            entry.last    = (age == fcwrb_pkg::CHANNEL_DEPTH - 1) &&
                            (ch == fcwrb_pkg::NUM_CHANNELS - 1);
            expected_window.push_back(entry);
         end
      end
   endtask

   always @(posedge clock) begin
      window_entry_type want;
      if (reset) begin
         clear_windows();
      end else begin
         // Results first: each one belongs to a readout accepted at an earlier edge.
         if (rsp_strobe) begin
            if (expected_window.size() == 0) begin
               $error("unexpected result: window_sample %h channel %0d age %0d last %0d",
                      rsp_window_sample, rsp_sample_channel, rsp_sample_age,
                      rsp_last_of_window);
               error_count++;
            end else begin
               want = expected_window.pop_front();
               if (rsp_window_sample !== want.sample) begin
                  $error("window_sample mismatch: expected %h actual %h",
                         want.sample, rsp_window_sample);
                  error_count++;
               end
               if (rsp_sample_channel !== want.channel) begin
                  $error("sample_channel mismatch: expected %0d actual %0d",
                         want.channel, rsp_sample_channel);
                  error_count++;
               end
               if (rsp_sample_age !== want.age) begin
                  $error("sample_age mismatch: expected %0d actual %0d",
                         want.age, rsp_sample_age);
                  error_count++;
               end
               if (rsp_last_of_window !== want.last) begin
                  $error("last_of_window mismatch: expected %0d actual %0d",
                         want.last, rsp_last_of_window);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            if (fcwrb_pkg::op_type'(req_operation) == fcwrb_pkg::OP_READ) begin
               predict_readout();
            end else begin
               store_sample(req_channel_code, req_sample_bits);
            end
         end
      end
      pending_results <= expected_window.size();
   end

endmodule

// File: tb/sv/testbench.sv
// Testbench top for the four-channel window ring buffer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int RANDOM_ITEMS = 240;
   localparam int QUIET_TAIL   = 40;
   localparam int CYCLE_LIMIT  = 100000;

   logic                               clock;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic                               req_operation;
   logic [fcwrb_pkg::CODE_W-1:0]       req_channel_code;
   logic [fcwrb_pkg::WORD_W-1:0]       req_sample_bits;
   logic                               rsp_strobe;
   logic [fcwrb_pkg::WORD_W-1:0]       rsp_window_sample;
   logic [fcwrb_pkg::CH_W-1:0]         rsp_sample_channel;
   logic [fcwrb_pkg::AGE_W-1:0]        rsp_sample_age;
   logic                               rsp_last_of_window;
   int                                 check_errors;
   int                                 pending_results;
   int                                 cycle_count;

   logic [fcwrb_pkg::WORD_W-1:0] corner_words [8] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE
   };

   four_channel_window_ring_buffer_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_channel_code   (req_channel_code),
      .req_sample_bits    (req_sample_bits),
      .rsp_strobe         (rsp_strobe),
      .rsp_window_sample  (rsp_window_sample),
      .rsp_sample_channel (rsp_sample_channel),
      .rsp_sample_age     (rsp_sample_age),
      .rsp_last_of_window (rsp_last_of_window)
   );

   window_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_channel_code   (req_channel_code),
      .req_sample_bits    (req_sample_bits),
      .rsp_strobe         (rsp_strobe),
      .rsp_window_sample  (rsp_window_sample),
      .rsp_sample_channel (rsp_sample_channel),
      .rsp_sample_age     (rsp_sample_age),
      .rsp_last_of_window (rsp_last_of_window),
      .error_count        (check_errors),
      .pending_results    (pending_results)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Present one item at the falling edge and hold it until the block takes it.
   task automatic send_item(input fcwrb_pkg::op_type op,
                            input logic [fcwrb_pkg::CODE_W-1:0] code,
                            input logic [fcwrb_pkg::WORD_W-1:0] word);
      @(negedge clock);
      start            <= 1'b1;
      req_operation    <= op;
      req_channel_code <= code;
      req_sample_bits  <= word;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_cycles(input int count);
      repeat (count) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   function automatic logic [fcwrb_pkg::WORD_W-1:0] random_word();
      if ($urandom_range(0, 7) == 0) begin
         return corner_words[$urandom_range(0, 7)];
      end
      return $urandom;
   endfunction

   initial begin
      int pick;
      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_operation    = fcwrb_pkg::OP_PUSH;
      req_channel_code = '0;
      req_sample_bits  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Readout of the freshly cleared windows, with noise in the ignored fields.
      send_item(fcwrb_pkg::OP_READ, 4'hF, 32'hFFFF_FFFF);
      // Every sensor code once: only 3..6 land in a window.
      for (int c = 0; c < 16; c++) begin
         send_item(fcwrb_pkg::OP_PUSH, fcwrb_pkg::CODE_W'(c), corner_words[c % 8]);
      end
      send_item(fcwrb_pkg::OP_PUSH, fcwrb_pkg::CODE_FIRST, 32'hFFFF_FFFF);
      send_item(fcwrb_pkg::OP_PUSH, fcwrb_pkg::CODE_LAST, 32'h0000_0000);
      send_item(fcwrb_pkg::OP_PUSH, 4'd4, 32'h8000_0000);
      send_item(fcwrb_pkg::OP_PUSH, 4'd5, 32'h7FFF_FFFF);
      send_item(fcwrb_pkg::OP_READ, 4'h0, 32'h0000_0000);
      send_item(fcwrb_pkg::OP_READ, 4'h5, 32'h1234_5678);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            idle_cycles($urandom_range(1, 9));
         end
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_item(fcwrb_pkg::OP_READ, fcwrb_pkg::CODE_W'($urandom), $urandom);
         end else if (pick < 20) begin
            // 7..18 folds onto the unused codes 7..15 and 0..2
            send_item(fcwrb_pkg::OP_PUSH, fcwrb_pkg::CODE_W'($urandom_range(7, 18)),
                      random_word());
         end else begin
            send_item(fcwrb_pkg::OP_PUSH, fcwrb_pkg::CODE_W'($urandom_range(3, 6)),
                      random_word());
         end
      end
      send_item(fcwrb_pkg::OP_READ, fcwrb_pkg::CODE_W'($urandom), $urandom);

      @(negedge clock);
      start <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (check_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
